/* sv/esbd_pkg.sv */
// esbd_pkg: types, microcode program and small helper functions for the
// epoch seconds to bcd date block; depends on nothing
package esbd_pkg;

	localparam int unsigned PC_W = 4;

	// datapath operation of one microcode step
	typedef enum logic [2:0] {
		OP_WAIT,   // take an input item
		OP_MUL,    // product register <= x * reciprocal
		OP_REM,    // x <= quotient, remainder to a field
		OP_DAYS,   // keep the day count, x <= days + epoch weekday
		OP_YEAR,   // take one year off the day count, repeat while possible
		OP_MONTH,  // take one month off, repeat while possible
		OP_OUT     // load the output register
	} op_t;

	// constant divisor in use
	typedef enum logic [1:0] {
		DV_60,
		DV_24,
		DV_7
	} div_t;

	// where a remainder goes
	typedef enum logic [1:0] {
		DST_SEC,
		DST_MIN,
		DST_HOUR,
		DST_WDAY
	} dst_t;

	typedef struct packed {
		op_t             op;
		div_t            dv;
		dst_t            dst;
		logic [PC_W-1:0] tgt;
	} uword_t;

	localparam logic [PC_W-1:0] PC_START = 4'd0;
	localparam logic [PC_W-1:0] PC_YEAR  = 4'd10;
	localparam logic [PC_W-1:0] PC_MONTH = 4'd11;
	localparam logic [PC_W-1:0] PC_OUT   = 4'd12;

	localparam logic [2:0]  EPOCH_WDAY   = 3'd4;
	localparam logic [8:0]  COMMON_YEAR  = 9'd365;
	localparam logic [3:0]  LAST_MONTH   = 4'd11;
	localparam logic [6:0]  CENTURY_OFS  = 7'd30;   // years from 1970 to 2000

	// reciprocals: floor(x / d) = (x * m) >> s, exact over the input range
	localparam logic [31:0] RCP_60 = 32'd2290649225;  // s = 37
	localparam logic [31:0] RCP_24 = 32'd2863311531;  // s = 36
	localparam logic [31:0] RCP_7  = 32'd2454267027;  // s = 34

	// the program
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_WAIT, dv: DV_60, dst: DST_SEC, tgt: PC_START};
		unique case (pc)
			4'd0:  w = '{op: OP_WAIT,  dv: DV_60, dst: DST_SEC,  tgt: PC_START};
			4'd1:  w = '{op: OP_MUL,   dv: DV_60, dst: DST_SEC,  tgt: PC_START};
			4'd2:  w = '{op: OP_REM,   dv: DV_60, dst: DST_SEC,  tgt: PC_START};
			4'd3:  w = '{op: OP_MUL,   dv: DV_60, dst: DST_MIN,  tgt: PC_START};
			4'd4:  w = '{op: OP_REM,   dv: DV_60, dst: DST_MIN,  tgt: PC_START};
			4'd5:  w = '{op: OP_MUL,   dv: DV_24, dst: DST_HOUR, tgt: PC_START};
			4'd6:  w = '{op: OP_REM,   dv: DV_24, dst: DST_HOUR, tgt: PC_START};
			4'd7:  w = '{op: OP_DAYS,  dv: DV_7,  dst: DST_WDAY, tgt: PC_START};
			4'd8:  w = '{op: OP_MUL,   dv: DV_7,  dst: DST_WDAY, tgt: PC_START};
			4'd9:  w = '{op: OP_REM,   dv: DV_7,  dst: DST_WDAY, tgt: PC_START};
			PC_YEAR:  w = '{op: OP_YEAR,  dv: DV_60, dst: DST_SEC,  tgt: PC_YEAR};
			PC_MONTH: w = '{op: OP_MONTH, dv: DV_60, dst: DST_SEC,  tgt: PC_MONTH};
			PC_OUT:   w = '{op: OP_OUT,   dv: DV_60, dst: DST_SEC,  tgt: PC_START};
			default: w = '{op: OP_WAIT, dv: DV_60, dst: DST_SEC, tgt: PC_START};
		endcase
		return w;
	endfunction

	// days in month m (0 = january)
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1:                       len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

	// two bcd digits of v (v below 100), tens via multiply by 205 >> 11
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p    = 15'(v) * 15'd205;
		tens = p[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

endpackage

/* sv/epoch_seconds_to_bcd_date_top.sv */
// epoch_seconds_to_bcd_date_top: epoch seconds to rtc bcd date and time,
// a microcoded sequencer over one shared reciprocal multiplier; uses esbd_pkg
// steps: take the item, then multiply and remainder for seconds, minutes, hours, weekday,
// then year steps and month steps while a whole one remains, then the output load
// the result sits in an output register, so a new item is taken while it waits
// reset clears the step counter and the output valid; payload is not reset
module epoch_seconds_to_bcd_date_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] seconds_since_epoch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  seconds_bcd,
	output logic [6:0]  minutes_bcd,
	output logic [5:0]  hours_bcd,
	output logic [2:0]  weekday,
	output logic [5:0]  day_bcd,
	output logic [4:0]  month_bcd,
	output logic [7:0]  year_bcd,
	output logic [5:0]  century_bcd
);

	// step counter and current control word
	logic [esbd_pkg::PC_W-1:0] pc_q;
	esbd_pkg::uword_t          uw;

	// datapath registers
	logic [30:0] x_q;       // value being divided
	logic [62:0] prod_q;    // x times reciprocal
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;
	logic [14:0] days_q;    // days since epoch, then day of year, then day of month
	logic [6:0]  year_q;    // years since 1970
	logic [3:0]  month_q;   // 0 = january

	// output register
	logic        out_valid_q;
	logic [6:0]  sec_bcd_q;
	logic [6:0]  min_bcd_q;
	logic [5:0]  hour_bcd_q;
	logic [2:0]  wday_out_q;
	logic [5:0]  day_bcd_q;
	logic [4:0]  mon_bcd_q;
	logic [7:0]  year_bcd_q;
	logic [5:0]  cent_bcd_q;

	// combinational helpers
	logic [31:0] rcp;
	logic [5:0]  divisor;
	logic [30:0] quot;
	logic [30:0] qd;
	logic [30:0] rem;
	logic        leap;
	logic [8:0]  year_len;
	logic [4:0]  mon_len;
	logic        year_step;
	logic        month_step;
	logic        out_free;
	logic        in_fire;
	logic [6:0]  yy;
	logic [7:0]  day_bcd_n;
	logic [7:0]  mon_bcd_n;
	logic [7:0]  cent_bcd_n;
	logic [7:0]  sec_bcd_n;
	logic [7:0]  min_bcd_n;
	logic [7:0]  hour_bcd_n;
	logic [esbd_pkg::PC_W-1:0] pc_next;

	assign uw = esbd_pkg::ucode_rom(pc_q);

	// reciprocal, divisor and quotient tap for the divisor in use
	always_comb begin
		rcp     = esbd_pkg::RCP_60;
		divisor = 6'd60;
		quot    = 31'(prod_q[62:37]);
		unique case (uw.dv)
			esbd_pkg::DV_60: begin
				rcp     = esbd_pkg::RCP_60;
				divisor = 6'd60;
				quot    = 31'(prod_q[62:37]);
			end
			esbd_pkg::DV_24: begin
				rcp     = esbd_pkg::RCP_24;
				divisor = 6'd24;
				quot    = 31'(prod_q[62:36]);
			end
			esbd_pkg::DV_7: begin
				rcp     = esbd_pkg::RCP_7;
				divisor = 6'd7;
				quot    = 31'(prod_q[62:34]);
			end
			default: begin
				rcp     = esbd_pkg::RCP_60;
				divisor = 6'd60;
				quot    = 31'(prod_q[62:37]);
			end
		endcase
	end

	// remainder: quotient times a small constant stays below x
	assign qd  = quot * 31'(divisor);
	assign rem = x_q - qd;

	// 1970 + y is a leap year when y mod 4 is 2
	assign leap       = (year_q[1:0] == 2'd2);
	assign year_len   = esbd_pkg::COMMON_YEAR + 9'(leap);
	assign mon_len    = esbd_pkg::month_len(month_q, leap);
	assign year_step  = (days_q >= 15'(year_len));
	assign month_step = (month_q < esbd_pkg::LAST_MONTH) && (days_q >= 15'(mon_len));

	// output register is free when empty or being emptied this cycle
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (uw.op == esbd_pkg::OP_WAIT);
	assign in_fire  = in_ready && in_valid;

	// year within the century and bcd conversion of the finished fields
	assign yy         = (year_q >= esbd_pkg::CENTURY_OFS) ? (year_q - esbd_pkg::CENTURY_OFS)
	                                                      : (year_q + 7'd70);
	assign sec_bcd_n  = esbd_pkg::to_bcd(7'(sec_q));
	assign min_bcd_n  = esbd_pkg::to_bcd(7'(min_q));
	assign hour_bcd_n = esbd_pkg::to_bcd(7'(hour_q));
	assign day_bcd_n  = esbd_pkg::to_bcd(7'(days_q[4:0]) + 7'd1);
	assign mon_bcd_n  = esbd_pkg::to_bcd(7'(month_q) + 7'd1);
	assign cent_bcd_n = (year_q >= esbd_pkg::CENTURY_OFS) ? 8'h20 : 8'h19;

	// sequencer: fall through, loop on self, or jump to the word's target
	always_comb begin
		pc_next = pc_q + 1'b1;
		unique case (uw.op)
			esbd_pkg::OP_WAIT:  pc_next = in_fire ? (pc_q + 1'b1) : pc_q;
			esbd_pkg::OP_YEAR:  pc_next = year_step ? uw.tgt : (pc_q + 1'b1);
			esbd_pkg::OP_MONTH: pc_next = month_step ? uw.tgt : (pc_q + 1'b1);
			esbd_pkg::OP_OUT:   pc_next = out_free ? uw.tgt : pc_q;
			default:            pc_next = pc_q + 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= esbd_pkg::PC_START;
		end else begin
			pc_q <= pc_next;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (uw.op)
			esbd_pkg::OP_WAIT: begin
				if (in_fire) begin
					x_q <= seconds_since_epoch;
				end
			end
			esbd_pkg::OP_MUL: begin
				prod_q <= 63'(x_q) * 63'(rcp);
			end
			esbd_pkg::OP_REM: begin
				x_q <= quot;
				case (uw.dst)
					esbd_pkg::DST_SEC:  sec_q  <= rem[5:0];
					esbd_pkg::DST_MIN:  min_q  <= rem[5:0];
					esbd_pkg::DST_HOUR: hour_q <= rem[4:0];
					default:            wday_q <= rem[2:0];
				endcase
			end
			esbd_pkg::OP_DAYS: begin
				days_q  <= x_q[14:0];
				x_q     <= x_q + 31'(esbd_pkg::EPOCH_WDAY);
				year_q  <= '0;
				month_q <= '0;
			end
			esbd_pkg::OP_YEAR: begin
				if (year_step) begin
					days_q <= days_q - 15'(year_len);
					year_q <= year_q + 7'd1;
				end
			end
			esbd_pkg::OP_MONTH: begin
				if (month_step) begin
					days_q  <= days_q - 15'(mon_len);
					month_q <= month_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == esbd_pkg::OP_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == esbd_pkg::OP_OUT && out_free) begin
			sec_bcd_q  <= sec_bcd_n[6:0];
			min_bcd_q  <= min_bcd_n[6:0];
			hour_bcd_q <= hour_bcd_n[5:0];
			wday_out_q <= wday_q;
			day_bcd_q  <= day_bcd_n[5:0];
			mon_bcd_q  <= mon_bcd_n[4:0];
			year_bcd_q <= esbd_pkg::to_bcd(yy);
			cent_bcd_q <= cent_bcd_n[5:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign seconds_bcd = sec_bcd_q;
	assign minutes_bcd = min_bcd_q;
	assign hours_bcd   = hour_bcd_q;
	assign weekday     = wday_out_q;
	assign day_bcd     = day_bcd_q;
	assign month_bcd   = mon_bcd_q;
	assign year_bcd    = year_bcd_q;
	assign century_bcd = cent_bcd_q;

endmodule
